// ===== design/adcap_pkg.sv =====
package adcap_pkg;

	// Delay memory; depth must be a power of two so that pointer arithmetic wraps for free.
	localparam int DEPTH  = 131072;
	localparam int AW     = $clog2(DEPTH);
	localparam int SW     = 16;
	localparam int DLY_W  = 17;
	localparam int GAIN_W = 16;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 17;

	// gain (unsigned, one guard bit) times sample
	localparam int PROD_W = SW + GAIN_W + 1;
	// product after the Q1.15 shift
	localparam int Q_W    = PROD_W - 15;
	localparam int SUM_W  = Q_W + 1;

	localparam logic [DLY_W-1:0]  RST_ECHO_DELAY    = DLY_W'(2205);
	localparam logic [DLY_W-1:0]  RST_COMB_DELAY    = DLY_W'(1306);
	localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0] RST_ECHO_DECAY    = GAIN_W'(16384);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_COMB    = 2'd1,
		MODE_ALLPASS = 2'd2,
		MODE_ECHO    = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE          = 3'd0,
		REG_ECHO_DELAY    = 3'd1,
		REG_COMB_DELAY    = 3'd2,
		REG_FEEDBACK_GAIN = 3'd3,
		REG_ECHO_DECAY    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		mode_t             mode;
		logic [DLY_W-1:0]  echo_delay;
		logic [DLY_W-1:0]  comb_delay;
		logic [GAIN_W-1:0] feedback_gain;
		logic [GAIN_W-1:0] echo_decay;
	} cfg_t;

	// read side of the delay memory for the item at the input
	typedef struct packed {
		logic [AW-1:0] raddr;
		logic          filled;  // entry written since reset
		logic [AW-1:0] waddr;
	} rd_req_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [SW-1:0] wdata;
	} wr_req_t;

	// round(gain * s / 2^15), ties toward plus infinity
	function automatic logic signed [Q_W-1:0] q15_mul(input logic [GAIN_W-1:0] gain,
			input logic signed [SW-1:0] s);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'($signed({1'b0, gain})) * PROD_W'(s);
		p = p + PROD_W'(16384);
		return $signed(p[PROD_W-1:15]);
	endfunction

	function automatic logic signed [SW-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SW-1:0];
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/adcap_ram.sv =====
module adcap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/adcap_cfg.sv =====
module adcap_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [adcap_pkg::IDX_W-1:0]   cfg_index,
	input  logic [adcap_pkg::CFG_W-1:0]   cfg_data,
	output adcap_pkg::cfg_t               cfg
);

	adcap_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= adcap_pkg::MODE_PLAIN;
			cfg_q.echo_delay    <= adcap_pkg::RST_ECHO_DELAY;
			cfg_q.comb_delay    <= adcap_pkg::RST_COMB_DELAY;
			cfg_q.feedback_gain <= adcap_pkg::RST_FEEDBACK_GAIN;
			cfg_q.echo_decay    <= adcap_pkg::RST_ECHO_DECAY;
		end else if (cfg_valid) begin
			unique case (adcap_pkg::reg_idx_t'(cfg_index))
				adcap_pkg::REG_MODE: begin
					cfg_q.mode <= adcap_pkg::mode_t'(cfg_data[1:0]);
				end
				adcap_pkg::REG_ECHO_DELAY: begin
					cfg_q.echo_delay <= cfg_data[adcap_pkg::DLY_W-1:0];
				end
				adcap_pkg::REG_COMB_DELAY: begin
					cfg_q.comb_delay <= cfg_data[adcap_pkg::DLY_W-1:0];
				end
				adcap_pkg::REG_FEEDBACK_GAIN: begin
					cfg_q.feedback_gain <= cfg_data[adcap_pkg::GAIN_W-1:0];
				end
				adcap_pkg::REG_ECHO_DECAY: begin
					cfg_q.echo_decay <= cfg_data[adcap_pkg::GAIN_W-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

endmodule

// ===== design/adcap_addr.sv =====
module adcap_addr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adcap_pkg::cfg_t      cfg,
	input  logic                 issue,
	output adcap_pkg::rd_req_t   req
);

	logic [adcap_pkg::AW-1:0]    wp_q;
	logic                        wrap_q;
	logic [adcap_pkg::DLY_W-1:0] d_raw;
	logic [adcap_pkg::AW-1:0]    d_eff;
	logic [adcap_pkg::AW-1:0]    raddr;

	always_comb begin
		if (cfg.mode == adcap_pkg::MODE_PLAIN || cfg.mode == adcap_pkg::MODE_ECHO) begin
			d_raw = cfg.echo_delay;
		end else begin
			d_raw = cfg.comb_delay;
		end
		priority if (d_raw == '0) begin
			d_eff = adcap_pkg::AW'(1);
		end else if (32'(d_raw) >= adcap_pkg::DEPTH) begin
			d_eff = adcap_pkg::AW'(adcap_pkg::DEPTH - 1);
		end else begin
			d_eff = adcap_pkg::AW'(d_raw);
		end
		raddr = wp_q - d_eff;
	end

	// Until the pointer first wraps, only entries below it have been written;
	// the rest read as zero without a clearing pass.
	assign req.raddr  = raddr;
	assign req.filled = wrap_q || (raddr < wp_q);
	assign req.waddr  = wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			wrap_q <= 1'b0;
		end else if (issue) begin
			wp_q <= wp_q + 1'b1;
			if (wp_q == adcap_pkg::AW'(adcap_pkg::DEPTH - 1)) begin
				wrap_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/adcap_dp.sv =====
module adcap_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  adcap_pkg::cfg_t             cfg,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [adcap_pkg::SW-1:0]    s_tdata,
	input  adcap_pkg::rd_req_t          req,
	input  logic [adcap_pkg::SW-1:0]    rdata,
	output logic                        issue,
	output adcap_pkg::wr_req_t          wr,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [adcap_pkg::SW-1:0]    m_tdata
);

	logic                              s1_v_q;
	logic signed [adcap_pkg::SW-1:0]   x_s1;
	logic [adcap_pkg::AW-1:0]          wa_s1;
	logic                              filled_s1;

	logic                              s2_v_q;
	logic signed [adcap_pkg::SW-1:0]   x_s2;
	logic signed [adcap_pkg::SW-1:0]   m_s2;
	logic signed [adcap_pkg::Q_W-1:0]  qs_s2;
	logic signed [adcap_pkg::Q_W-1:0]  qo_s2;
	logic [adcap_pkg::AW-1:0]          wa_s2;

	logic                              out_v_q;
	logic [adcap_pkg::SW-1:0]          out_q;

	logic                              out_free, s2_free, s1_free;
	logic                              s2_go, s1_go, hazard;
	logic signed [adcap_pkg::SW-1:0]   m;
	logic [adcap_pkg::GAIN_W-1:0]      g_store;
	logic signed [adcap_pkg::Q_W-1:0]  qs, qo;
	logic signed [adcap_pkg::SW-1:0]   stored, result;

	assign out_free = !out_v_q || m_tready;
	assign s2_go    = s2_v_q && out_free;
	assign s2_free  = !s2_v_q || out_free;
	assign s1_go    = s1_v_q && s2_free;
	assign s1_free  = !s1_v_q || s2_free;

	// Entries still in flight have not reached memory; the read-first RAM
	// would return stale data, so hold the input until they land.
	assign hazard   = (s1_v_q && req.raddr == wa_s1) || (s2_v_q && req.raddr == wa_s2);
	assign s_tready = s1_free && !hazard;
	assign issue    = s_tvalid && s_tready;

	// s1: delayed sample arrives from memory, both gain products
	always_comb begin
		m       = filled_s1 ? $signed(rdata) : '0;
		g_store = (cfg.mode == adcap_pkg::MODE_ECHO) ? cfg.echo_decay : cfg.feedback_gain;
		qs      = adcap_pkg::q15_mul(g_store, m);
		qo      = adcap_pkg::q15_mul(cfg.feedback_gain, x_s1);
	end

	// s2: sums and saturation
	always_comb begin
		unique case (cfg.mode)
			adcap_pkg::MODE_PLAIN: begin
				stored = x_s2;
				result = adcap_pkg::sat(adcap_pkg::SUM_W'(x_s2) + adcap_pkg::SUM_W'(m_s2));
			end
			adcap_pkg::MODE_COMB: begin
				stored = adcap_pkg::sat(adcap_pkg::SUM_W'(x_s2) + adcap_pkg::SUM_W'(qs_s2));
				result = adcap_pkg::sat(adcap_pkg::SUM_W'(x_s2) + adcap_pkg::SUM_W'(m_s2));
			end
			default: begin
				stored = adcap_pkg::sat(adcap_pkg::SUM_W'(x_s2) + adcap_pkg::SUM_W'(qs_s2));
				result = adcap_pkg::sat(adcap_pkg::SUM_W'(m_s2) - adcap_pkg::SUM_W'(qo_s2));
			end
		endcase
	end

	assign wr.we    = s2_go;
	assign wr.waddr = wa_s2;
	assign wr.wdata = stored;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= issue;
			end
			if (s2_free) begin
				s2_v_q <= s1_v_q;
			end
			if (out_free) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1      <= $signed(s_tdata);
			wa_s1     <= req.waddr;
			filled_s1 <= req.filled;
		end
		if (s1_go) begin
			x_s2  <= x_s1;
			m_s2  <= m;
			qs_s2 <= qs;
			qo_s2 <= qo;
			wa_s2 <= wa_s1;
		end
		if (s2_go) begin
			out_q <= result;
		end
	end

endmodule

// ===== design/audio_delay_line_comb_allpass_top.sv =====
// Delay line with plain delay, feedback comb, allpass and echo forms on signed
// 16-bit samples. One sample is taken per clock unless the input is held for
// a memory hazard or the output is back-pressured; each result passes the s1,
// s2 and output registers (read the delay memory, form the Q1.15 products,
// sum, saturate and write back). The dual-port delay memory sets the rate:
// a delay of one sample (or zero, which acts as one) makes each item wait for
// the previous write-back, and a delay of two samples makes every other item
// wait for an earlier write-back; longer delays run at one item per cycle. No
// clearing pass follows reset: entries above the write pointer read as zero
// until the pointer first wraps. The user must write registers over the cfg
// channel (index 0 mode, 1 echo delay, 2 comb delay, 3 feedback gain, 4 echo
// decay) only while no sample is in flight; the block itself does not enforce it.
module audio_delay_line_comb_allpass_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [adcap_pkg::IDX_W-1:0] cfg_index,
	input  logic [adcap_pkg::CFG_W-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] sample_in
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata    // [15:0] sample_out
);

	adcap_pkg::cfg_t           cfg;
	adcap_pkg::rd_req_t        req;
	adcap_pkg::wr_req_t        wr;
	logic                      issue;
	logic [adcap_pkg::SW-1:0]  rdata;

	adcap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	adcap_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.issue  (issue),
		.req    (req)
	);

	adcap_ram #(
		.WIDTH (adcap_pkg::SW),
		.DEPTH (adcap_pkg::DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.waddr),
		.wdata (wr.wdata),
		.re    (issue),
		.raddr (req.raddr),
		.rdata (rdata)
	);

	adcap_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.req      (req),
		.rdata    (rdata),
		.issue    (issue),
		.wr       (wr),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef NO_ASSERTIONS
	// a read never races a write-back to the same entry
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.we && issue && wr.waddr == req.raddr))
		else $error("delay memory read and write hit the same entry");

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (req.waddr == adcap_pkg::AW'($past(req.waddr) + 1'b1)))
		else $error("write pointer did not advance on a transaction");

	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!issue |=> $stable(req.waddr))
		else $error("write pointer moved without a transaction");

	a_out_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(wr.we))
		else $error("result presented without its write-back");
`endif

endmodule
